// ===== rtl/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the session token table
// slot count, field widths, status codes and controller/datapath interface
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam int SLOTS      = 64;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TOKEN_W    = 256;
    localparam int TIME_W     = 32;
    localparam int OUT_SLOT_W = 6;
    localparam int IN_DATA_W  = 552;
    localparam int OUT_DATA_W = 40;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    localparam logic [31:0] SESSION_LENGTH_RST = 32'd28800;
    localparam logic [3:0]  FAILURE_LIMIT_RST  = 4'd5;
    localparam logic [15:0] LOCKOUT_LENGTH_RST = 16'd60;

    localparam logic [1:0] KIND_LOGIN  = 2'd1;
    localparam logic [1:0] KIND_LOGOUT = 2'd2;

    localparam logic [1:0] CFG_SESSION_LENGTH = 2'd0;
    localparam logic [1:0] CFG_FAILURE_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_LOCKOUT_LENGTH = 2'd2;

    typedef enum logic [2:0] {
        ST_SIGNED_IN      = 3'd0,
        ST_NOT_SIGNED_IN  = 3'd1,
        ST_LOGIN_ACCEPTED = 3'd2,
        ST_LOGIN_REJECTED = 3'd3,
        ST_LOCKED_OUT     = 3'd4,
        ST_LOGGED_OUT     = 3'd5
    } status_t;

    typedef struct packed {
        logic start_look;
        logic start_min;
        logic clear_match;
        logic commit_login;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
        logic login_ok;
        logic logout;
    } stat_t;

endpackage

// ===== rtl/stt_ram.sv =====
// ----------------------------------------------------------------------------
// stt_ram: generic single-port-write, single-port-read ram
// one write and one registered read per cycle
// ----------------------------------------------------------------------------
module stt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/stt_ctrl.sv =====
// ----------------------------------------------------------------------------
// stt_ctrl: sequencer of the session token table
// steps a request through lookup and slot release; an accepted login adds minimum search and commit
// ----------------------------------------------------------------------------
module stt_ctrl
    import stt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_LOOK   = 6'b000010,
        S_CLEAR  = 6'b000100,
        S_MIN    = 6'b001000,
        S_WRITE  = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.start_look = 1'b1;
                    state_next     = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_CLEAR;
                end
            end
            S_CLEAR:
            begin
                cmd.clear_match = stat.login_ok | stat.logout;
                cmd.start_min   = stat.login_ok;
                state_next      = stat.login_ok ? S_MIN : S_FINISH;
            end
            S_MIN:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.commit_login = 1'b1;
                state_next       = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/stt_dp.sv =====
// ----------------------------------------------------------------------------
// stt_dp: datapath of the session token table
// request registers, slot stores, scan engine, lockout state and result beat
// ----------------------------------------------------------------------------
module stt_dp
    import stt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output stat_t                 stat,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [2:0]            m_tuser
);

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // configuration
    logic [31:0] session_length_reg;
    logic [3:0]  failure_limit_reg;
    logic [15:0] lockout_length_reg;

    // request
    logic [1:0]         kind_reg;
    logic [TIME_W-1:0]  now_reg;
    logic               present_reg;
    logic [TOKEN_W-1:0] tok_reg;
    logic               cred_reg;
    logic [TOKEN_W-1:0] new_tok_reg;

    // lockout
    logic [3:0]        failure_count_reg;
    logic [3:0]        failure_count_next;
    logic [TIME_W-1:0] locked_until_reg;
    logic [TIME_W-1:0] locked_until_next;
    logic [4:0]        fail_sum;

    // scan engine
    logic              issue_reg;
    logic              issue_next;
    logic              mode_min_reg;
    logic              mode_min_next;
    logic [SLOT_W-1:0] addr_reg;
    logic [SLOT_W-1:0] addr_next;
    logic              rd_vld_reg;
    logic [SLOT_W-1:0] rd_idx_reg;

    logic [SLOTS-1:0]  valid_reg;
    logic [SLOTS-1:0]  valid_next;

    logic              match_found_reg;
    logic              match_found_next;
    logic [SLOT_W-1:0] match_idx_reg;
    logic [SLOT_W-1:0] match_idx_next;
    logic [SLOT_W-1:0] best_idx_reg;
    logic [SLOT_W-1:0] best_idx_next;
    logic [TIME_W-1:0] best_exp_reg;
    logic [TIME_W-1:0] best_exp_next;
    logic [TIME_W-1:0] exp_new_reg;
    logic [TIME_W-1:0] exp_new;

    logic [TOKEN_W-1:0] tok_rdata;
    logic [TIME_W-1:0]  exp_rdata;
    logic [TIME_W-1:0]  exp_eff;
    logic               look_hit;

    // result register
    logic                  out_valid_reg;
    logic                  out_valid_next;
    status_t               out_status_reg;
    status_t               out_status;
    logic [OUT_SLOT_W-1:0] out_slot_reg;
    logic [OUT_SLOT_W-1:0] out_slot;
    logic                  out_sv_reg;
    logic                  out_sv;
    logic [TIME_W-1:0]     out_exp_reg;
    logic [TIME_W-1:0]     out_exp;

    logic is_login;
    logic is_logout;
    logic locked;
    logic login_fail;
    logic login_ok;

    stt_ram #(
        .WIDTH (TOKEN_W),
        .DEPTH (SLOTS)
    ) u_token_ram (
        .clk   (clk),
        .we    (cmd.commit_login),
        .waddr (best_idx_reg),
        .wdata (new_tok_reg),
        .raddr (addr_reg),
        .rdata (tok_rdata)
    );

    stt_ram #(
        .WIDTH (TIME_W),
        .DEPTH (SLOTS)
    ) u_expiry_ram (
        .clk   (clk),
        .we    (cmd.commit_login),
        .waddr (best_idx_reg),
        .wdata (exp_new),
        .raddr (addr_reg),
        .rdata (exp_rdata)
    );

    assign is_login   = (kind_reg == KIND_LOGIN);
    assign is_logout  = (kind_reg == KIND_LOGOUT);
    assign locked     = (locked_until_reg > now_reg);
    assign login_fail = is_login & ~locked & ~cred_reg;
    assign login_ok   = is_login & ~locked & cred_reg;
    assign exp_new    = sat_add(now_reg, session_length_reg);
    assign fail_sum   = {1'b0, failure_count_reg} + 5'd1;

    // slots never written since reset read as zero expiry
    assign exp_eff  = valid_reg[rd_idx_reg] ? exp_rdata : '0;
    assign look_hit = present_reg & (exp_eff > now_reg) & (tok_rdata == tok_reg);

    assign stat.scan_done = rd_vld_reg & (rd_idx_reg == LAST_SLOT);
    assign stat.out_free  = ~out_valid_reg | m_tready;
    assign stat.login_ok  = login_ok;
    assign stat.logout    = is_logout;

    // scan engine and slot bookkeeping
    always_comb
    begin
        issue_next       = issue_reg;
        mode_min_next    = mode_min_reg;
        addr_next        = addr_reg;
        valid_next       = valid_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        best_idx_next    = best_idx_reg;
        best_exp_next    = best_exp_reg;

        if (issue_reg)
        begin
            if (addr_reg == LAST_SLOT)
            begin
                issue_next = 1'b0;
            end
            else
            begin
                addr_next = addr_reg + SLOT_W'(1);
            end
        end

        if (rd_vld_reg)
        begin
            if (mode_min_reg)
            begin
                if ((rd_idx_reg == '0) || (exp_eff < best_exp_reg))
                begin
                    best_idx_next = rd_idx_reg;
                    best_exp_next = exp_eff;
                end
            end
            else if (look_hit && !match_found_reg)
            begin
                match_found_next = 1'b1;
                match_idx_next   = rd_idx_reg;
            end
        end

        if (cmd.start_look || cmd.start_min)
        begin
            issue_next    = 1'b1;
            addr_next     = '0;
            mode_min_next = cmd.start_min;
        end
        if (cmd.start_look)
        begin
            match_found_next = 1'b0;
        end

        if (cmd.clear_match && match_found_reg)
        begin
            valid_next[match_idx_reg] = 1'b0;
        end
        if (cmd.commit_login)
        begin
            valid_next[best_idx_reg] = 1'b1;
        end
    end

    // lockout bookkeeping
    always_comb
    begin
        failure_count_next = failure_count_reg;
        locked_until_next  = locked_until_reg;
        if (cmd.finish && login_fail)
        begin
            if (fail_sum >= {1'b0, failure_limit_reg})
            begin
                locked_until_next  = sat_add(now_reg, {16'd0, lockout_length_reg});
                failure_count_next = '0;
            end
            else
            begin
                failure_count_next = fail_sum[3:0];
            end
        end
        else if (cmd.finish && login_ok)
        begin
            failure_count_next = '0;
        end
    end

    // result beat
    always_comb
    begin
        out_status = ST_NOT_SIGNED_IN;
        out_slot   = '0;
        out_sv     = 1'b0;
        out_exp    = '0;
        priority if (is_login)
        begin
            priority if (locked)
            begin
                out_status = ST_LOCKED_OUT;
            end
            else if (!cred_reg)
            begin
                out_status = ST_LOGIN_REJECTED;
            end
            else
            begin
                out_status = ST_LOGIN_ACCEPTED;
                out_slot   = OUT_SLOT_W'(best_idx_reg);
                out_sv     = 1'b1;
                out_exp    = exp_new_reg;
            end
        end
        else if (is_logout)
        begin
            out_status = ST_LOGGED_OUT;
            if (match_found_reg)
            begin
                out_slot = OUT_SLOT_W'(match_idx_reg);
                out_sv   = 1'b1;
            end
        end
        else if (match_found_reg)
        begin
            out_status = ST_SIGNED_IN;
            out_slot   = OUT_SLOT_W'(match_idx_reg);
            out_sv     = 1'b1;
        end
        else
        begin
            out_status = ST_NOT_SIGNED_IN;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_length_reg <= SESSION_LENGTH_RST;
            failure_limit_reg  <= FAILURE_LIMIT_RST;
            lockout_length_reg <= LOCKOUT_LENGTH_RST;
            failure_count_reg  <= '0;
            locked_until_reg   <= '0;
            issue_reg          <= 1'b0;
            mode_min_reg       <= 1'b0;
            addr_reg           <= '0;
            rd_vld_reg         <= 1'b0;
            rd_idx_reg         <= '0;
            valid_reg          <= '0;
            match_found_reg    <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SESSION_LENGTH: session_length_reg <= cfg_data;
                    CFG_FAILURE_LIMIT:  failure_limit_reg  <= cfg_data[3:0];
                    CFG_LOCKOUT_LENGTH: lockout_length_reg <= cfg_data[15:0];
                    default:            ;
                endcase
            end
            failure_count_reg <= failure_count_next;
            locked_until_reg  <= locked_until_next;
            issue_reg         <= issue_next;
            mode_min_reg      <= mode_min_next;
            addr_reg          <= addr_next;
            rd_vld_reg        <= issue_reg;
            rd_idx_reg        <= addr_reg;
            valid_reg         <= valid_next;
            match_found_reg   <= match_found_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_look)
        begin
            kind_reg    <= s_tuser;
            now_reg     <= s_tdata[31:0];
            present_reg <= s_tdata[32];
            tok_reg     <= s_tdata[288:33];
            cred_reg    <= s_tdata[289];
            new_tok_reg <= s_tdata[545:290];
        end
        match_idx_reg <= match_idx_next;
        best_idx_reg  <= best_idx_next;
        best_exp_reg  <= best_exp_next;
        if (cmd.commit_login)
        begin
            exp_new_reg <= exp_new;
        end
        if (cmd.finish)
        begin
            out_status_reg <= out_status;
            out_slot_reg   <= out_slot;
            out_sv_reg     <= out_sv;
            out_exp_reg    <= out_exp;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_exp_reg, out_sv_reg, out_slot_reg};
    assign m_tuser  = out_status_reg;

endmodule

// ===== rtl/session_token_table_lockout.sv =====
// ----------------------------------------------------------------------------
// session_token_table_lockout: session slot table with login lockout
// Slave channel s_*: one beat per request, kind in s_tuser, time, presented
// token, credential verdict and fresh token in s_tdata.
// Master channel m_*: one result beat per request, status in m_tuser.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 session
// length, 1 failure limit, 2 lockout length); the user must write only while
// idle, which the block itself does not enforce. One request at a time:
// s_tready is high only while the sequencer is idle. Every request runs a
// lookup pass over all SLOTS slots in the token and expiry rams, one slot
// per cycle through a registered read; an accepted login adds a second pass
// that finds the slot with the smallest expiry. These passes set the rate.
// The result sits in an output register; if the receiver stalls, the next
// request is still accepted and processed, and waits for the register.
// Reset clears the expiry valid bits, the failure count and the lockout
// deadline, and loads the configuration defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module session_token_table_lockout
    import stt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // now, token_present, token_w0..w3, credentials_ok, new_w0..w3, zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // kind
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // slot, slot_valid, expiry, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    // status
    output logic [2:0]            m_tuser,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [31:0]           cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    stt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    stt_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== rtl/stt_checker.sv =====
// ----------------------------------------------------------------------------
// stt_checker: port-level checks of the session token table
// result beat consistency and one-request-at-a-time acceptance
// ----------------------------------------------------------------------------
module stt_checker
    import stt_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [2:0]            m_tuser
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // no request accepted right after another
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

    // slot is zero when not meaningful
    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[6] |-> m_tdata[5:0] == '0)
        else $error("slot nonzero without slot_valid");

    // expiry only on accepted login, which always carries a slot
    a_expiry_only_login: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ST_LOGIN_ACCEPTED) |-> m_tdata[38:7] == '0)
        else $error("expiry outside accepted login");

    a_login_slot: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_LOGIN_ACCEPTED) |-> m_tdata[6])
        else $error("accepted login without slot");

endmodule

bind session_token_table_lockout stt_checker u_stt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== dv/session_token_table_lockout_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// session_token_table_lockout_tb: self-checking bench for the session table
// Sends login, logout and request-check beats through the slave stream,
// predicts each result beat with its own copy of the slot table, failure
// count and lockout deadline, and compares every master beat field by field.
// Runs a directed opening, then random phases over several register
// settings (zero and maximum values among them) with sender gaps, receiver
// stalls, one long receiver hold-off and drained pauses between phases.
// ----------------------------------------------------------------------------
module session_token_table_lockout_tb;
    import stt_pkg::*;

    localparam logic [1:0] KIND_CHECK  = 2'd0;
    localparam logic [1:0] KIND_SPARE  = 2'd3;
    localparam int         HOLD_CYCLES = 800;
    localparam int         STALL_LIMIT = 4000;

    typedef struct {
        logic [1:0]   kind;
        logic [31:0]  now;
        logic         present;
        logic [255:0] tok;
        logic         cred;
        logic [255:0] fresh;
    } request_t;

    typedef struct {
        status_t     status;
        logic [5:0]  slot;
        logic        slot_valid;
        logic [31:0] expiry;
    } outcome_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [1:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [2:0]            m_tuser;
    logic                  cfg_we = 1'b0;
    logic [1:0]            cfg_index = '0;
    logic [31:0]           cfg_data = '0;

    // predicted state of the block
    logic [255:0] tok_mem [SLOTS];
    logic [31:0]  exp_mem [SLOTS];
    logic [3:0]   fail_cnt;
    logic [31:0]  lock_until;
    logic [31:0]  sess_len;
    logic [3:0]   fail_lim;
    logic [15:0]  lock_len;

    request_t     pending_reqs [$];
    outcome_t     expected_results [$];
    logic [255:0] issued_tokens [$];
    request_t     cur_req;

    logic [31:0] gen_now = 32'd1000;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int n_errors = 0;
    int n_requests = 0;
    int n_settings = 0;
    int idle_cycles = 0;
    int status_count [8];

    session_token_table_lockout u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic outcome_t predict_session(request_t r);
        outcome_t   o;
        int         hit;
        int         best;
        logic [4:0] cnt;
        hit = -1;
        o.status = ST_NOT_SIGNED_IN;
        o.slot = '0;
        o.slot_valid = 1'b0;
        o.expiry = '0;
        if (r.present)
        begin
            for (int i = SLOTS - 1; i >= 0; i--)
            begin
                if (exp_mem[i] > r.now && tok_mem[i] == r.tok)
                    hit = i;
            end
        end
        if (r.kind == KIND_LOGIN)
        begin
            if (lock_until > r.now)
                o.status = ST_LOCKED_OUT;
            else if (!r.cred)
            begin
                cnt = {1'b0, fail_cnt} + 5'd1;
                if (cnt >= {1'b0, fail_lim})
                begin
                    lock_until = sat_sum(r.now, {16'd0, lock_len});
                    cnt = '0;
                end
                fail_cnt = cnt[3:0];
                o.status = ST_LOGIN_REJECTED;
            end
            else
            begin
                fail_cnt = '0;
                if (hit >= 0)
                    exp_mem[hit] = '0;
                best = 0;
                for (int i = 1; i < SLOTS; i++)
                begin
                    if (exp_mem[i] < exp_mem[best])
                        best = i;
                end
                tok_mem[best] = r.fresh;
                o.expiry = sat_sum(r.now, sess_len);
                exp_mem[best] = o.expiry;
                o.status = ST_LOGIN_ACCEPTED;
                o.slot = OUT_SLOT_W'(best);
                o.slot_valid = 1'b1;
            end
        end
        else if (r.kind == KIND_LOGOUT)
        begin
            o.status = ST_LOGGED_OUT;
            if (hit >= 0)
            begin
                exp_mem[hit] = '0;
                o.slot = OUT_SLOT_W'(hit);
                o.slot_valid = 1'b1;
            end
        end
        else if (hit >= 0)
        begin
            o.status = ST_SIGNED_IN;
            o.slot = OUT_SLOT_W'(hit);
            o.slot_valid = 1'b1;
        end
        return o;
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_request(request_t r);
        return IN_DATA_W'({r.fresh, r.cred, r.tok, r.present, r.now});
    endfunction

    task automatic flag_error(string msg);
        $display("ERROR at %0t: %s", $time, msg);
        n_errors++;
    endtask

    task automatic check_result();
        outcome_t want;
        if (expected_results.size() == 0)
        begin
            flag_error($sformatf("result beat with nothing pending, status %0d", m_tuser));
            return;
        end
        want = expected_results.pop_front();
        status_count[m_tuser]++;
        if (m_tuser !== want.status)
            flag_error($sformatf("status %0d, want %0d", m_tuser, want.status));
        if (m_tdata[5:0] !== want.slot)
            flag_error($sformatf("slot %0d, want %0d", m_tdata[5:0], want.slot));
        if (m_tdata[6] !== want.slot_valid)
            flag_error($sformatf("slot_valid %0b, want %0b", m_tdata[6], want.slot_valid));
        if (m_tdata[38:7] !== want.expiry)
            flag_error($sformatf("expiry %h, want %h", m_tdata[38:7], want.expiry));
        if (m_tdata[39] !== 1'b0)
            flag_error("nonzero pad bit in result beat");
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                cur_req = pending_reqs.pop_front();
                expected_results.push_back(predict_session(cur_req));
                n_requests++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pack_request(pending_reqs[0]);
                    s_tuser  <= pending_reqs[0].kind;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
                check_result();
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (hold_seen != hold_req)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("no beat accepted for %0d cycles, %0d results outstanding",
                     idle_cycles, expected_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic set_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_SESSION_LENGTH: sess_len = val;
            CFG_FAILURE_LIMIT:  fail_lim = val[3:0];
            CFG_LOCKOUT_LENGTH: lock_len = val[15:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_settings(logic [31:0] sl, logic [31:0] fl, logic [31:0] ll);
        set_reg(CFG_SESSION_LENGTH, sl);
        set_reg(CFG_FAILURE_LIMIT, fl);
        set_reg(CFG_LOCKOUT_LENGTH, ll);
        n_settings++;
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic push_req(logic [1:0] kind, logic [31:0] now, logic present,
                            logic [255:0] tok, logic cred, logic [255:0] fresh);
        request_t r;
        r.kind = kind;
        r.now = now;
        r.present = present;
        r.tok = tok;
        r.cred = cred;
        r.fresh = fresh;
        pending_reqs.push_back(r);
    endtask

    function automatic logic [255:0] rand_token();
        return {$urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic logic [255:0] recent_token();
        int span;
        if (issued_tokens.size() == 0)
            return rand_token();
        span = (issued_tokens.size() > 8) ? 7 : issued_tokens.size() - 1;
        return issued_tokens[issued_tokens.size() - 1 - $urandom_range(span, 0)];
    endfunction

    function automatic logic [31:0] next_now();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            gen_now = gen_now + $urandom_range(20, 0);
        else if (roll < 98 && roll >= 90)
            gen_now = gen_now + $urandom_range(1000, 0);
        else if (roll >= 98)
            gen_now = gen_now + $urandom_range(100000, 0);
        return gen_now;
    endfunction

    task automatic gen_random(int n);
        request_t r;
        int       roll;
        for (int k = 0; k < n; k++)
        begin
            roll = $urandom_range(99);
            r.now = next_now();
            r.fresh = ($urandom_range(9) == 0) ? recent_token() : rand_token();
            r.tok = recent_token();
            r.present = 1'b1;
            r.cred = 1'b1;
            if (roll < 30)
            begin
                r.kind = KIND_LOGIN;
                r.cred = ($urandom_range(99) >= 20);
                r.present = 1'($urandom_range(1));
            end
            else if (roll < 75)
            begin
                r.kind = KIND_CHECK;
                r.present = ($urandom_range(19) != 0);
            end
            else if (roll < 90)
                r.kind = KIND_LOGOUT;
            else
            begin
                // noise: any kind, any time
                r.kind = 2'($urandom_range(3));
                r.now = $urandom;
                r.present = 1'($urandom_range(1));
                if ($urandom_range(1))
                    r.tok = rand_token();
            end
            if (r.kind == KIND_LOGIN)
                issued_tokens.push_back(r.fresh);
            pending_reqs.push_back(r);
        end
    endtask

    task automatic run_phase(int n, int s_pct, int r_pct);
        send_idle_pct = s_pct;
        recv_stall_pct = r_pct;
        gen_random(n);
        drain();
    endtask

    initial
    begin
        logic [255:0] tok_a;
        logic [255:0] tok_b;
        logic [255:0] tok_c;
        tok_a = '1;
        tok_b = rand_token();
        tok_c = rand_token();
        for (int i = 0; i < SLOTS; i++)
        begin
            tok_mem[i] = '0;
            exp_mem[i] = '0;
        end
        fail_cnt = '0;
        lock_until = '0;
        sess_len = SESSION_LENGTH_RST;
        fail_lim = FAILURE_LIMIT_RST;
        lock_len = LOCKOUT_LENGTH_RST;
        foreach (status_count[i])
            status_count[i] = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opening at reset settings
        push_req(KIND_CHECK, 32'd0, 1'b0, '0, 1'b0, '0);
        push_req(KIND_LOGOUT, 32'd0, 1'b0, '0, 1'b0, '0);
        push_req(KIND_SPARE, 32'd5, 1'b1, tok_a, 1'b0, '0);
        repeat (5) push_req(KIND_LOGIN, 32'd100, 1'b0, '0, 1'b0, tok_c);
        push_req(KIND_LOGIN, 32'd159, 1'b0, '0, 1'b1, tok_c);
        push_req(KIND_LOGIN, 32'd160, 1'b0, '0, 1'b1, tok_a);
        push_req(KIND_CHECK, 32'd200, 1'b1, tok_a, 1'b0, '0);
        push_req(KIND_LOGIN, 32'd210, 1'b1, tok_a, 1'b1, tok_b);
        push_req(KIND_CHECK, 32'd220, 1'b1, tok_a, 1'b0, '0);
        push_req(KIND_LOGIN, 32'd230, 1'b0, tok_a, 1'b1, '0);
        push_req(KIND_CHECK, 32'd240, 1'b1, '0, 1'b0, '0);
        push_req(KIND_LOGOUT, 32'd250, 1'b1, tok_b, 1'b0, '0);
        push_req(KIND_CHECK, 32'd260, 1'b1, tok_b, 1'b0, '0);
        push_req(KIND_LOGIN, 32'hFFFF_FFF0, 1'b0, '0, 1'b1, tok_b);
        push_req(KIND_CHECK, 32'hFFFF_FFFF, 1'b1, tok_b, 1'b0, '0);
        push_req(KIND_CHECK, 32'hFFFF_FFFE, 1'b1, tok_b, 1'b0, '0);
        push_req(KIND_SPARE, 32'hFFFF_FFFE, 1'b1, tok_b, 1'b0, '0);
        push_req(KIND_LOGIN, 32'd300, 1'b1, '1, 1'b0, '1);
        issued_tokens.push_back(tok_a);
        issued_tokens.push_back(tok_b);
        gen_now = 32'd400;
        drain();

        apply_settings(32'd300, 32'd3, 32'd60);
        run_phase(300, 0, 0);
        apply_settings(32'd0, 32'd0, 32'd0);
        run_phase(150, 78, 0);
        apply_settings(32'd1, 32'd1, 32'd1);
        run_phase(200, 0, 78);
        apply_settings(32'hFFFF_FFFF, 32'd15, 32'd65535);
        run_phase(200, 7, 7);

        // receiver holds off while the sender keeps offering
        apply_settings(32'd2000, 32'd4, 32'd500);
        @(negedge clk);
        hold_req = hold_req + 1;
        run_phase(300, 0, 0);

        apply_settings(32'd28800, 32'd5, 32'd60);
        run_phase(250, 7, 7);
        apply_settings($urandom_range(5000, 50), $urandom_range(15, 1), $urandom_range(500, 1));
        run_phase(200, 0, 78);

        // saturated lockout deadline at the top of the time range
        apply_settings(sess_len, 32'd2, 32'd65535);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (2) push_req(KIND_LOGIN, 32'hFFFF_FF00, 1'b0, '0, 1'b0, '0);
        push_req(KIND_LOGIN, 32'hFFFF_FFFE, 1'b0, '0, 1'b1, tok_c);
        push_req(KIND_LOGIN, 32'hFFFF_FFFF, 1'b0, '0, 1'b1, tok_c);
        push_req(KIND_CHECK, 32'hFFFF_FFFF, 1'b1, tok_c, 1'b0, '0);
        drain();
        repeat (150) @(posedge clk);

        $display("ran %0d requests over %0d register settings plus reset values",
                 n_requests, n_settings);
        $display("in %0d, out %0d, accepted %0d, rejected %0d, locked %0d, logouts %0d",
                 status_count[ST_SIGNED_IN], status_count[ST_NOT_SIGNED_IN],
                 status_count[ST_LOGIN_ACCEPTED], status_count[ST_LOGIN_REJECTED],
                 status_count[ST_LOCKED_OUT], status_count[ST_LOGGED_OUT]);
        if (n_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/stt_pkg.sv
rtl/stt_ram.sv
rtl/stt_ctrl.sv
rtl/stt_dp.sv
rtl/session_token_table_lockout.sv
rtl/stt_checker.sv
dv/session_token_table_lockout_tb.sv
